>>> hdl/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int ASCII_W    = 6;
  localparam int WIDEST_RUN = 10;

  localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;

  typedef struct packed {
    logic load;   // capture a new input word, clear digits
    logic conv;   // one shift-add-3 step
    logic shift;  // drop the top digit
    logic emit;   // load the top digit into the output register
    logic last;   // digit being emitted is the last of the run
  } cmd_t;

  typedef struct packed {
    logic top_zero;  // top stored digit is zero
    logic ovf;       // value has more digits than stored
    logic out_free;  // output register can take a digit this cycle
  } sts_t;

endpackage

>>> hdl/b2da_dp.sv
// Datapath: input register, BCD digit register with shift-add-3, output register.
module b2da_dp #(
  parameter int LIM = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [b2da_pkg::VALUE_W-1:0]   in_value,
  input  logic                           out_ready,
  input  b2da_pkg::cmd_t                 cmd,
  output b2da_pkg::sts_t                 sts,
  output logic                           out_valid,
  output logic [b2da_pkg::ASCII_W-1:0]   out_ascii_digit,
  output logic                           out_last_digit
);

  localparam int DW = b2da_pkg::DIGIT_W;
  localparam int BW = LIM * DW;

  logic [b2da_pkg::VALUE_W-1:0] bin_r;
  logic [LIM-1:0][DW-1:0]       dig_r;
  logic [LIM-1:0][DW-1:0]       adj;
  logic [BW-1:0]                adj_flat;
  logic                         ovf_r;
  logic                         out_valid_r;
  logic [b2da_pkg::ASCII_W-1:0] ascii_r;
  logic                         last_r;

  always_comb begin
    for (int i = 0; i < LIM; i++) begin
      if (dig_r[i] >= b2da_pkg::BCD_ADJ_MIN) begin
        adj[i] = dig_r[i] + b2da_pkg::BCD_ADJ;
      end else begin
        adj[i] = dig_r[i];
      end
    end
  end

  assign adj_flat = adj;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= in_value;
      dig_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.conv) begin
      bin_r <= bin_r << 1;
      dig_r <= {adj_flat[BW-2:0], bin_r[b2da_pkg::VALUE_W-1]};
      ovf_r <= ovf_r | adj_flat[BW-1];
    end else if (cmd.shift) begin
      dig_r <= dig_r << DW;
    end
    if (cmd.emit) begin
      ascii_r <= b2da_pkg::ASCII_ZERO + {{(b2da_pkg::ASCII_W-DW){1'b0}}, dig_r[LIM-1]};
      last_r  <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.top_zero = (dig_r[LIM-1] == '0);
  assign sts.ovf      = ovf_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_ascii_digit = ascii_r;
  assign out_last_digit  = last_r;

endmodule

>>> hdl/b2da_ctrl.sv
// Controller: sequences load, conversion steps and digit emission.
module b2da_ctrl #(
  parameter int LIM = 10
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  b2da_pkg::sts_t sts,
  output b2da_pkg::cmd_t cmd
);

  localparam int CNT_W = $clog2(b2da_pkg::VALUE_W);
  localparam int REM_W = $clog2(LIM + 1);
  localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(b2da_pkg::VALUE_W - 1);
  localparam logic [REM_W-1:0] REM_INIT = REM_W'(LIM);
  localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] bit_cnt_r;
  logic [REM_W-1:0] rem_r;
  logic             started_r;
  logic             emit_go;
  logic             skip;

  assign in_ready = (state_r == ST_IDLE);
  assign emit_go  = (state_r == ST_EMIT) && sts.out_free;
  assign skip     = sts.top_zero && !started_r && !sts.ovf && (rem_r != REM_ONE);

  assign cmd.load  = (state_r == ST_IDLE) && in_valid;
  assign cmd.conv  = (state_r == ST_CONV);
  assign cmd.shift = emit_go;
  assign cmd.emit  = emit_go && !skip;
  assign cmd.last  = (rem_r == REM_ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
      rem_r     <= '0;
      started_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r   <= ST_CONV;
            bit_cnt_r <= '0;
          end
        end
        ST_CONV: begin
          if (bit_cnt_r == BIT_LAST) begin
            state_r   <= ST_EMIT;
            rem_r     <= REM_INIT;
            started_r <= 1'b0;
          end else begin
            bit_cnt_r <= bit_cnt_r + 1'b1;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            rem_r <= rem_r - 1'b1;
            if (!skip) begin
              started_r <= 1'b1;
            end
            if (rem_r == REM_ONE) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/binary_to_decimal_ascii_core.sv
// Top level of the binary to decimal ASCII converter.
// Each input word is a 32-bit unsigned number; the block returns its decimal
// text as one output word per ASCII digit, most significant first, without
// leading zeros, with out_last_digit marking the final digit (zero gives "0").
// Only the lowest min(MAX_DIGITS, 10) digits, but at least one, are kept; a
// longer number is cut to that many, which may start with '0'. A word is
// accepted in the idle state and converted by a bit-serial shift-add-3 loop
// (one input bit per cycle); its stored digits then go out one per cycle while
// the output is not stalled, leading zeros being dropped one per cycle as well.
// A new word is taken once the last digit sits in the output register.
module binary_to_decimal_ascii_core #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [b2da_pkg::VALUE_W-1:0]        in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [b2da_pkg::ASCII_W-1:0]        out_ascii_digit,
  output logic                                out_last_digit
);

  localparam int LIM = (MAX_DIGITS > b2da_pkg::WIDEST_RUN) ? b2da_pkg::WIDEST_RUN :
                       (MAX_DIGITS < 1) ? 1 : MAX_DIGITS;

  b2da_pkg::cmd_t cmd;
  b2da_pkg::sts_t sts;

  b2da_ctrl #(
    .LIM (LIM)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  b2da_dp #(
    .LIM (LIM)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_value        (in_value),
    .out_ready       (out_ready),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ascii_digit (out_ascii_digit),
    .out_last_digit  (out_last_digit)
  );

`ifndef SYNTHESIS
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ascii_digit >= 6'd48) && (out_ascii_digit <= 6'd57))
    else $error("output digit out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while converting");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_digit) |=> out_valid)
    else $error("gap inside a digit run");
`endif

endmodule
